FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int COUNT_BITS    = 5;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                      operation;
        logic [PAYLOAD_BITS-1:0]         item_data;
        logic signed [PRIORITY_BITS-1:0] item_priority;
    } cmd_t;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] result_data;
        logic [1:0]              error_code;
        logic [COUNT_BITS-1:0]   entry_count;
    } result_t;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0]         data;
        logic signed [PRIORITY_BITS-1:0] prio;
    } entry_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-priority queue kept sorted in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Each beat on cmd is taken when start is high and busy is low; busy stays
// low, so one operation is accepted every clock. Every cell compares its own
// priority with the new key in parallel and then shifts or loads, so
// the result of a beat appears on result, marked by done, in the cycle right
// after it was accepted and lasts exactly one cycle. The receiver cannot hold
// results off. Insert on a full queue returns ERR_FULL, remove or peek on an
// empty queue returns ERR_EMPTY with zero data; equal priorities leave
// last-in first-out.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output      logic    busy,
    input  wire cmd_t    cmd,
    output      logic    done,
    output      result_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;

    cell_ctrl_t       ctrl;
    entry_t           new_entry;
    entry_t           cell_entry [CAPACITY];
    logic             cell_ge    [CAPACITY];
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign new_entry.data = cmd.item_data;
    assign new_entry.prio = cmd.item_priority;

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        result_next = '0;
        if (accept)
        begin
            unique case (cmd.operation) inside
                OP_INSERT:
                begin
                    if (count_reg == CNT_FULL)
                        result_next.error_code = ERR_FULL;
                    else
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CNT_ONE;
                    end
                end
                OP_REMOVE, OP_PEEK:
                begin
                    if (count_reg == '0)
                        result_next.error_code = ERR_EMPTY;
                    else
                    begin
                        result_next.result_data = cell_entry[0].data;
                        if (cmd.operation == OP_REMOVE)
                        begin
                            ctrl.rem   = 1'b1;
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                end
                default:
                begin
                    // unused code: no change
                end
            endcase
            result_next.entry_count = COUNT_BITS'(count_next);
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_g;

            if (i == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_g = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[i-1];
                assign left_g = cell_ge[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_e = cell_entry[i];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[i+1];
            end

            spq_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .count       (count_reg),
                .left_entry  (left_e),
                .left_ge     (left_g),
                .right_entry (right_e),
                .entry       (cell_entry[i]),
                .ge          (cell_ge[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the new key
// and takes its own value, the new entry, or a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire entry_t           new_entry,
    input  wire logic [CNT_W-1:0] count,
    input  wire entry_t           left_entry,
    input  wire logic             left_ge,
    input  wire entry_t           right_entry,
    output      entry_t           entry,
    output      logic             ge
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;

    // new key goes at or ahead of this slot (slots past the count always qualify)
    assign ge = (MY_IDX >= count) || (new_entry.prio >= entry_reg.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (left_ge)
                entry_next = left_entry;
            else if (ge)
                entry_next = new_entry;
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
